// ===== rtl/grac_pkg.sv =====
// Shared types, constants and control structs for the clipped grid rectangle adder.
package grac_pkg;

    localparam int COORD_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = 7;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SKIP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_RECT = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_MAX  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_CELL = 2'd1,
        RES_MAX  = 2'd2
    } res_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic                capture;
        logic                decode;
        logic                load;
        logic                step;
        logic                finish;
        res_kind_t           res_kind;
        logic [STATUS_W-1:0] status;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        func_t func;
        logic  in_grid;
        logic  skip;
        logic  empty;
        logic  scan_last;
        logic  pipe_busy;
    } dp_stat_t;

endpackage

// ===== rtl/grid_rectangle_add_with_clip_top.sv =====
// Top level of the clipped rectangle adder over a two-copy height grid.
//
// Usage: drive func and its operands and raise start; the request is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the request completes. One result per request: done pulses for a
// single cycle with cell_value, change and status; the receiver must take
// it then, it cannot stall the block. A new request may be started in the
// same cycle that done is high.
// A rectangle add or largest-change report walks its cells one per cycle
// through the read-modify-write pipe of the grid memories.
// Grid size: write row_count (index 0) or col_count (index 1) on the cfg
// port while idle; sizes above MAX_ROWS / MAX_COLS saturate.
// Reset: sizes return to 64 by 64, the sequencer goes idle. Grid contents
// are not cleared; a cell must be loaded before it is read or reported.
module grid_rectangle_add_with_clip_top #(
    parameter int MAX_ROWS = grac_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = grac_pkg::MAX_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [grac_pkg::FUNC_W-1:0]         func,
    input  logic signed [grac_pkg::COORD_W-1:0] row_first,
    input  logic signed [grac_pkg::COORD_W-1:0] col_first,
    input  logic signed [grac_pkg::COORD_W-1:0] row_last,
    input  logic signed [grac_pkg::COORD_W-1:0] col_last,
    input  logic signed [grac_pkg::VALUE_W-1:0] amount,
    // size registers
    input  logic                                cfg_we,
    input  logic [grac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grac_pkg::CFG_DATA_W-1:0]     cfg_data,
    // result channel
    output logic                                done,
    output logic signed [grac_pkg::VALUE_W-1:0] cell_value,
    output logic [grac_pkg::VALUE_W-1:0]        change,
    output logic [grac_pkg::STATUS_W-1:0]       status
);

    grac_pkg::ctrl_cmd_t cmd;
    grac_pkg::dp_stat_t  stat;

    // sequencer: decode, scan stepping, pipeline drain, done strobe
    grac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: clipping, counters, grid memories, result registers
    grac_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .row_first  (row_first),
        .col_first  (col_first),
        .row_last   (row_last),
        .col_last   (col_last),
        .amount     (amount),
        .cmd        (cmd),
        .stat       (stat),
        .cell_value (cell_value),
        .change     (change),
        .status     (status)
    );

endmodule

// ===== rtl/grac_ctrl.sv =====
// Request sequencer: decodes each request and steps the datapath through it.
module grac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  grac_pkg::dp_stat_t   stat,
    output grac_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLASSIFY,
        S_SCAN,
        S_DRAIN,
        S_READ_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.res_kind = grac_pkg::RES_NONE;
        cmd.status   = grac_pkg::STATUS_OK;
        state_next   = state_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_CLASSIFY;
            end
            S_CLASSIFY:
            begin
                case (stat.func)
                    grac_pkg::FUNC_LOAD:
                    begin
                        cmd.load   = stat.in_grid;
                        cmd.finish = 1'b1;
                        cmd.status = stat.in_grid ? grac_pkg::STATUS_OK
                                                  : grac_pkg::STATUS_RANGE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    grac_pkg::FUNC_RECT:
                    begin
                        if (stat.skip || stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = stat.skip ? grac_pkg::STATUS_SKIP
                                                   : grac_pkg::STATUS_OK;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    grac_pkg::FUNC_READ:
                    begin
                        if (stat.in_grid)
                        begin
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = grac_pkg::STATUS_RANGE;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // largest change; an empty grid reports zero
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_kind = (stat.func == grac_pkg::FUNC_MAX) ? grac_pkg::RES_MAX
                                                                     : grac_pkg::RES_NONE;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ_WAIT:
            begin
                cmd.finish   = 1'b1;
                cmd.res_kind = grac_pkg::RES_CELL;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== rtl/grac_dp.sv =====
// Datapath: size registers, request fields, clipping, scan counters, grid memories, results.
module grac_dp #(
    parameter int MAX_ROWS = grac_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = grac_pkg::MAX_COLS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [grac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [grac_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [grac_pkg::FUNC_W-1:0]            func,
    input  logic signed [grac_pkg::COORD_W-1:0]    row_first,
    input  logic signed [grac_pkg::COORD_W-1:0]    col_first,
    input  logic signed [grac_pkg::COORD_W-1:0]    row_last,
    input  logic signed [grac_pkg::COORD_W-1:0]    col_last,
    input  logic signed [grac_pkg::VALUE_W-1:0]    amount,
    input  grac_pkg::ctrl_cmd_t                    cmd,
    output grac_pkg::dp_stat_t                     stat,
    output logic signed [grac_pkg::VALUE_W-1:0]    cell_value,
    output logic [grac_pkg::VALUE_W-1:0]           change,
    output logic [grac_pkg::STATUS_W-1:0]          status
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CW     = grac_pkg::COORD_W;
    localparam int VW     = grac_pkg::VALUE_W;

    localparam logic signed [CW:0] ZERO_X = '0;
    localparam logic signed [CW:0] ONE_X  = (CW+1)'(1);

    // size registers
    logic [grac_pkg::CNT_W-1:0] row_count_reg;
    logic [grac_pkg::CNT_W-1:0] col_count_reg;

    // request fields
    grac_pkg::func_t     func_reg;
    logic signed [CW-1:0] r1_reg, c1_reg, r2_reg, c2_reg;
    logic [VW-1:0]       amount_reg;

    // scan bounds and counters
    logic [ROW_W-1:0] row_ctr_reg, row_hi_reg;
    logic [COL_W-1:0] col_ctr_reg, col_lo_reg, col_hi_reg;
    logic             inside_reg, skip_reg, empty_reg;

    // memories and pipeline
    logic [VW-1:0]     orig_mem [DEPTH];
    logic [VW-1:0]     cur_mem  [DEPTH];
    logic [VW-1:0]     cur_rd_reg, orig_rd_reg;
    logic              s1_valid_reg, s2_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [VW-1:0]     absd_reg, max_reg;

    // result
    logic [VW-1:0]                 value_reg, change_reg;
    logic [grac_pkg::STATUS_W-1:0] status_reg;

    logic [CW-1:0]      rows_use, cols_use;
    logic signed [CW:0] rows_x, cols_x, r1_x, c1_x, r2_x, c2_x;
    logic signed [CW:0] lo_r_x, hi_r_x, lo_c_x, hi_c_x;
    logic               inside_c, skip_c, empty_c;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VW-1:0]      diff, abs_c;
    logic               cur_we;
    logic [ADDR_W-1:0]  cur_waddr;
    logic [VW-1:0]      cur_wdata;
    logic               row_end, col_end;

    // counts above the grid size saturate
    assign rows_use = (CW'(row_count_reg) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(row_count_reg);
    assign cols_use = (CW'(col_count_reg) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(col_count_reg);

    assign rows_x = {1'b0, rows_use};
    assign cols_x = {1'b0, cols_use};
    assign r1_x   = {r1_reg[CW-1], r1_reg};
    assign c1_x   = {c1_reg[CW-1], c1_reg};
    assign r2_x   = {r2_reg[CW-1], r2_reg};
    assign c2_x   = {c2_reg[CW-1], c2_reg};

    assign inside_c = (r1_x >= ZERO_X) && (r1_x < rows_x) && (c1_x >= ZERO_X) && (c1_x < cols_x);
    assign skip_c   = (r1_x >= rows_x) || (c1_x >= cols_x) || (r2_x < ZERO_X) || (c2_x < ZERO_X);

    always_comb
    begin
        case (func_reg)
            grac_pkg::FUNC_MAX:
            begin
                lo_r_x = ZERO_X;
                hi_r_x = rows_x - ONE_X;
                lo_c_x = ZERO_X;
                hi_c_x = cols_x - ONE_X;
            end
            grac_pkg::FUNC_RECT:
            begin
                lo_r_x = (r1_x < ZERO_X) ? ZERO_X : r1_x;
                hi_r_x = (r2_x >= rows_x) ? (rows_x - ONE_X) : r2_x;
                lo_c_x = (c1_x < ZERO_X) ? ZERO_X : c1_x;
                hi_c_x = (c2_x >= cols_x) ? (cols_x - ONE_X) : c2_x;
            end
            default:
            begin
                // single cell at the first corner
                lo_r_x = r1_x;
                hi_r_x = r1_x;
                lo_c_x = c1_x;
                hi_c_x = c1_x;
            end
        endcase
    end

    assign empty_c = (lo_r_x > hi_r_x) || (lo_c_x > hi_c_x);

    assign row_end = (row_ctr_reg == row_hi_reg);
    assign col_end = (col_ctr_reg == col_hi_reg);
    assign rd_addr = {row_ctr_reg, col_ctr_reg};

    assign diff  = cur_rd_reg - orig_rd_reg;
    assign abs_c = diff[VW-1] ? (VW'(0) - diff) : diff;

    always_comb
    begin
        cur_we    = 1'b0;
        cur_waddr = rd_addr;
        cur_wdata = amount_reg;
        if (cmd.load)
        begin
            cur_we = 1'b1;
        end
        else if (s1_valid_reg && (func_reg == grac_pkg::FUNC_RECT))
        begin
            cur_we    = 1'b1;
            cur_waddr = s1_addr_reg;
            cur_wdata = cur_rd_reg + amount_reg;
        end
    end

    // config and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= grac_pkg::COUNT_RESET;
            col_count_reg <= grac_pkg::COUNT_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    grac_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                    grac_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            s1_valid_reg <= cmd.step;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= grac_pkg::func_t'(func);
            r1_reg     <= row_first;
            c1_reg     <= col_first;
            r2_reg     <= row_last;
            c2_reg     <= col_last;
            amount_reg <= amount;
        end

        if (cmd.decode)
        begin
            row_ctr_reg <= lo_r_x[ROW_W-1:0];
            row_hi_reg  <= hi_r_x[ROW_W-1:0];
            col_ctr_reg <= lo_c_x[COL_W-1:0];
            col_lo_reg  <= lo_c_x[COL_W-1:0];
            col_hi_reg  <= hi_c_x[COL_W-1:0];
            inside_reg  <= inside_c;
            skip_reg    <= skip_c;
            empty_reg   <= empty_c;
        end
        else if (cmd.step)
        begin
            if (col_end)
            begin
                col_ctr_reg <= col_lo_reg;
                row_ctr_reg <= row_ctr_reg + ROW_W'(1);
            end
            else
            begin
                col_ctr_reg <= col_ctr_reg + COL_W'(1);
            end
        end

        s1_addr_reg <= rd_addr;
        absd_reg    <= abs_c;

        if (cmd.decode)
        begin
            max_reg <= '0;
        end
        else if (s2_valid_reg && (absd_reg > max_reg))
        begin
            max_reg <= absd_reg;
        end

        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            case (cmd.res_kind)
                grac_pkg::RES_CELL:
                begin
                    value_reg  <= cur_rd_reg;
                    change_reg <= abs_c;
                end
                grac_pkg::RES_MAX:
                begin
                    value_reg  <= '0;
                    change_reg <= max_reg;
                end
                default:
                begin
                    value_reg  <= '0;
                    change_reg <= '0;
                end
            endcase
        end
    end

    // grid memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            orig_mem[rd_addr] <= amount_reg;
        end
        orig_rd_reg <= orig_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rd_reg <= cur_mem[rd_addr];
    end

    assign stat.func      = func_reg;
    assign stat.in_grid   = inside_reg;
    assign stat.skip      = skip_reg;
    assign stat.empty     = empty_reg;
    assign stat.scan_last = row_end && col_end;
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg;

    assign cell_value = value_reg;
    assign change     = change_reg;
    assign status     = status_reg;

endmodule
